FILE: hdl/streaming_kth_largest_heap_core_assert.svh
// Assertion macros for the streaming k-th largest heap core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STREAMING_KTH_LARGEST_HEAP_CORE_ASSERT_SVH
`define STREAMING_KTH_LARGEST_HEAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SKTH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skth assertion failed");
`define SKTH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skth assertion failed");
`else
`define SKTH_ASSERT_SAME(label, clk, rst, ante, cons)
`define SKTH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/skth_pkg.sv
// Shared constants and types for the streaming k-th largest heap core.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps
package skth_pkg;
   localparam int HEAP_CAPACITY = 64;
   localparam int ADDR_W        = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
   localparam int FILL_W        = $clog2(HEAP_CAPACITY + 1);
   localparam int CHILD_W       = ADDR_W + 2;
   localparam int VALUE_W       = 16;
   localparam int RANK_W        = 7;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [FILL_W-1:0]         fill_type;
   typedef logic [RANK_W-1:0]         rank_type;
endpackage

FILE: hdl/skth_stream_if.sv
// Valid/ready stream interfaces for sample requests and k-th value responses.
// Depends on skth_pkg for the value type.
`timescale 1ns / 1ps
interface skth_req_if;
   import skth_pkg::*;
   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      set_end;
   modport source (output valid, output sample_value, output set_end, input ready);
   modport sink (input valid, input sample_value, input set_end, output ready);
endinterface

interface skth_rsp_if;
   import skth_pkg::*;
   logic      valid;
   logic      ready;
   value_type kth_value;
   logic      set_short;
   modport source (output valid, output kth_value, output set_short, input ready);
   modport sink (input valid, input kth_value, input set_short, output ready);
endinterface

FILE: hdl/streaming_kth_largest_heap_core.sv
// Streaming k-th largest selector: min-heap of up to k entries in one RAM.
// Depends on skth_pkg, skth_stream_if.sv and streaming_kth_largest_heap_core_assert.svh.
// Flow: an accepted item that enters the heap walks it level by level (S_UP or S_DN) through
// the RAM read ports; the block takes no new sample until it is back in S_IDLE.
// A set_end transaction then passes S_EMIT, which loads the response register once the output is free.
// Reset: synchronous; clears fill count, response valid and rank (to 1); RAM is not cleared.
`timescale 1ns / 1ps
`include "streaming_kth_largest_heap_core_assert.svh"
module streaming_kth_largest_heap_core (
   input  logic                   clock,
   input  logic                   reset,
   skth_req_if.sink               req_chan,
   skth_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [skth_pkg::RANK_W-1:0] csr_wr_data
);
   import skth_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_UP   = 4'b0010,
      S_DN   = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   value_type heap_mem [HEAP_CAPACITY];

   state_type state_ff, state_in, after_state;
   fill_type  fill_ff, fill_in, k_eff, k_ff;
   rank_type  rank_ff;
   addr_type  idx_ff, idx_in;
   value_type val_ff, top_ff, kth_ff;
   logic      last_ff, short_ff, rsp_valid_ff;

   logic      wr_en;
   addr_type  wr_addr, rd_addr_a, rd_addr_b;
   value_type wr_data, rd_a_ff, rd_b_ff;

   logic      req_fire, do_push, rsp_free, emit_go;

   logic [CHILD_W-1:0] l_w, r_w, n_w, nl_w;
   logic      l_ok, r_ok, dn_take;
   value_type dn_best;
   addr_type  dn_child;

   function automatic addr_type parent_of(input addr_type a);
      return (a - 1'b1) >> 1;
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kth_value = kth_ff;
   assign rsp_chan.set_short = short_ff;

   always_comb begin
      if (rank_ff == '0) begin
         k_eff = FILL_W'(1);
      end else if (int'(rank_ff) > HEAP_CAPACITY) begin
         k_eff = FILL_W'(HEAP_CAPACITY);
      end else begin
         k_eff = FILL_W'(rank_ff);
      end
   end

   assign do_push = fill_ff < k_eff;
   assign after_state = last_ff ? S_EMIT : S_IDLE;

   // sift-down child selection, ties go to the left child
   assign l_w  = {1'b0, idx_ff, 1'b1};
   assign r_w  = l_w + 1'b1;
   assign n_w  = CHILD_W'(fill_ff);
   assign l_ok = l_w < n_w;
   assign r_ok = r_w < n_w;

   always_comb begin
      dn_best  = val_ff;
      dn_child = l_w[ADDR_W-1:0];
      dn_take  = 1'b0;
      if (l_ok && rd_a_ff < dn_best) begin
         dn_best = rd_a_ff;
         dn_take = 1'b1;
      end
      if (r_ok && rd_b_ff < dn_best) begin
         dn_best  = rd_b_ff;
         dn_child = r_w[ADDR_W-1:0];
         dn_take  = 1'b1;
      end
   end

   assign nl_w = {1'b0, dn_child, 1'b1};

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = val_ff;
      rd_addr_a = parent_of(idx_ff);
      rd_addr_b = idx_ff;
      emit_go   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (do_push) begin
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_chan.sample_value;
                     state_in = req_chan.set_end ? S_EMIT : S_IDLE;
                  end else begin
                     idx_in    = fill_ff[ADDR_W-1:0];
                     rd_addr_a = parent_of(fill_ff[ADDR_W-1:0]);
                     state_in  = S_UP;
                  end
               end else if (req_chan.sample_value > top_ff) begin
                  idx_in    = '0;
                  rd_addr_a = ADDR_W'(1);
                  rd_addr_b = ADDR_W'(2);
                  state_in  = S_DN;
               end else begin
                  state_in = req_chan.set_end ? S_EMIT : S_IDLE;
               end
            end
         end
         S_UP: begin
            wr_en = 1'b1;
            if (idx_ff == '0 || rd_a_ff <= val_ff) begin
               state_in = after_state;
            end else begin
               wr_data   = rd_a_ff;
               idx_in    = parent_of(idx_ff);
               rd_addr_a = parent_of(parent_of(idx_ff));
            end
         end
         S_DN: begin
            wr_en = 1'b1;
            if (!dn_take) begin
               state_in = after_state;
            end else begin
               wr_data   = dn_best;
               idx_in    = dn_child;
               rd_addr_a = nl_w[ADDR_W-1:0];
               rd_addr_b = nl_w[ADDR_W-1:0] + 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               emit_go  = 1'b1;
               fill_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rank_ff      <= RANK_W'(1);
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            rank_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_fire) begin
         val_ff  <= req_chan.sample_value;
         last_ff <= req_chan.set_end;
         k_ff    <= k_eff;
      end
      if (emit_go) begin
         kth_ff   <= top_ff;
         short_ff <= fill_ff < k_ff;
      end
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   `SKTH_ASSERT_SAME(a_write_in_heap, clock, reset, wr_en && state_ff != S_IDLE, FILL_W'(wr_addr) < fill_ff)
   `SKTH_ASSERT_NEXT(a_push_grows, clock, reset, req_fire && do_push, fill_ff == $past(fill_ff) + 1'b1)
   `SKTH_ASSERT_NEXT(a_sift_descends, clock, reset, state_ff == S_DN && state_in == S_DN, idx_ff > $past(idx_ff))
   `SKTH_ASSERT_NEXT(a_emit_clears, clock, reset, emit_go, fill_ff == '0 && rsp_valid_ff)
endmodule
